// ===== rtl/ccam_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, register indexes, calendar limits and the month-length and
// leap-year helpers used by the calendar clock with alarm match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccam_pkg;

   // Kind of request word.
   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_LOAD = 1'b1
   } req_kind_type;

   // Configuration register indexes.
   localparam int          CSR_INDEX_BITS = 4;
   localparam int          CSR_DATA_BITS  = 16;
   localparam logic [3:0]  CSR_ENABLE       = 4'd0;
   localparam logic [3:0]  CSR_ALARM_MODE   = 4'd1;
   localparam logic [3:0]  CSR_ALARM_SECOND = 4'd2;
   localparam logic [3:0]  CSR_ALARM_MINUTE = 4'd3;
   localparam logic [3:0]  CSR_ALARM_HOUR   = 4'd4;
   localparam logic [3:0]  CSR_ALARM_DAY    = 4'd5;
   localparam logic [3:0]  CSR_ALARM_MONTH  = 4'd6;
   localparam logic [3:0]  CSR_ALARM_YEAR   = 4'd7;

   // Alarm modes; each mode adds one more field to the compare.
   localparam logic [2:0]  ALARM_OFF          = 3'd0;
   localparam logic [2:0]  ALARM_SS           = 3'd1;
   localparam logic [2:0]  ALARM_MMSS         = 3'd2;
   localparam logic [2:0]  ALARM_HHMMSS       = 3'd3;
   localparam logic [2:0]  ALARM_DDHHMMSS     = 3'd4;
   localparam logic [2:0]  ALARM_MMDDHHMMSS   = 3'd5;
   localparam logic [2:0]  ALARM_YYMMDDHHMMSS = 3'd6;

   // Calendar limits, sized for the carry sums in the cascade.
   localparam logic [6:0]  SEC_WRAP        = 7'd60;
   localparam logic [6:0]  MIN_WRAP        = 7'd60;
   localparam logic [5:0]  HOUR_WRAP       = 6'd24;
   localparam logic [5:0]  FEB_SHORT_DAYS  = 6'd28;
   localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;

   // Reset values of the time counters.
   localparam logic [15:0] YEAR_DEFAULT  = 16'd2000;
   localparam logic [3:0]  MONTH_DEFAULT = 4'd1;
   localparam logic [4:0]  DAY_DEFAULT   = 5'd1;

   // Multiplicative inverse of 25 modulo 2^16 and the largest product that
   // marks a multiple of 25.
   localparam logic [15:0] INV_25     = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
   } time_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
   } alarm_cfg_type;

   // Gregorian leap year. A multiple of 25 is found by multiplying with the
   // inverse of 25: the low half of the product is small only for multiples.
   function automatic logic leap_of(input logic [15:0] year);
      logic [31:0] prod;
      logic        div25;
      prod  = year * INV_25;
      div25 = (prod[15:0] <= DIV25_LIMIT);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   // Days in a month. Months outside 1..12 count as 30-day months.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd2:                                   len = leap ? 5'd29 : 5'd28;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                                len = 5'd30;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ccam_csr.sv =====
// ----------------------------------------------------------------------------
// Calendar clock configuration registers
// Holds the enable bit and the alarm registers written over the CSR port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccam_csr #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [ccam_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ccam_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output ccam_pkg::alarm_cfg_type                   alarm_cfg,
   output logic      [YEAR_BITS-1:0]                 alarm_year,
   output logic                                      enable
);

   ccam_pkg::alarm_cfg_type cfg_ff;
   logic [YEAR_BITS-1:0]    year_ff;
   logic                    enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         cfg_ff.mode   <= ccam_pkg::ALARM_OFF;
         cfg_ff.second <= 6'd0;
         cfg_ff.minute <= 6'd0;
         cfg_ff.hour   <= 5'd0;
         cfg_ff.day    <= ccam_pkg::DAY_DEFAULT;
         cfg_ff.month  <= ccam_pkg::MONTH_DEFAULT;
         year_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ccam_pkg::CSR_ENABLE:       enable_ff     <= csr_wdata[0];
            ccam_pkg::CSR_ALARM_MODE:   cfg_ff.mode   <= csr_wdata[2:0];
            ccam_pkg::CSR_ALARM_SECOND: cfg_ff.second <= csr_wdata[5:0];
            ccam_pkg::CSR_ALARM_MINUTE: cfg_ff.minute <= csr_wdata[5:0];
            ccam_pkg::CSR_ALARM_HOUR:   cfg_ff.hour   <= csr_wdata[4:0];
            ccam_pkg::CSR_ALARM_DAY:    cfg_ff.day    <= csr_wdata[4:0];
            ccam_pkg::CSR_ALARM_MONTH:  cfg_ff.month  <= csr_wdata[3:0];
            ccam_pkg::CSR_ALARM_YEAR:   year_ff       <= csr_wdata[YEAR_BITS-1:0];
            default: begin
               // Writes to unmapped indexes are dropped.
            end
         endcase
      end
   end

   assign alarm_cfg  = cfg_ff;
   assign alarm_year = year_ff;
   assign enable     = enable_ff;

endmodule

`default_nettype wire

// ===== rtl/ccam_time.sv =====
// ----------------------------------------------------------------------------
// Calendar clock time counters
// Time and date registers with the one-second carry cascade and a leap flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccam_time #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick_en,
   input  wire logic                     load_en,
   input  ccam_pkg::time_type            load_time,
   input  wire logic [YEAR_BITS-1:0]     load_year,
   output ccam_pkg::time_type            time_next,
   output logic      [YEAR_BITS-1:0]     year_next
);

   localparam logic [YEAR_BITS-1:0] YEAR_RESET = ccam_pkg::YEAR_DEFAULT[YEAR_BITS-1:0];

   ccam_pkg::time_type    time_ff;
   logic [YEAR_BITS-1:0]  year_ff;
   logic                  leap_ff;

   ccam_pkg::time_type    tick_time;
   logic [YEAR_BITS-1:0]  tick_year;
   logic [6:0]            sec_sum;
   logic [6:0]            min_sum;
   logic [5:0]            hour_sum;
   logic [5:0]            day_sum;
   logic [4:0]            month_sum;
   logic [4:0]            days_in_month;
   logic                  sec_carry;
   logic                  min_carry;
   logic                  hour_carry;
   logic                  day_carry;
   logic                  month_carry;
   logic [YEAR_BITS-1:0]  leap_year_src;

   // Each field is normalized whether or not a carry reaches it, so loaded
   // values beyond range clear on the next enabled tick.
   always_comb begin
      sec_sum     = {1'b0, time_ff.second} + 7'd1;
      sec_carry   = (sec_sum >= ccam_pkg::SEC_WRAP);
      min_sum     = {1'b0, time_ff.minute} + {6'd0, sec_carry};
      min_carry   = (min_sum >= ccam_pkg::MIN_WRAP);
      hour_sum    = {1'b0, time_ff.hour} + {5'd0, min_carry};
      hour_carry  = (hour_sum >= ccam_pkg::HOUR_WRAP);
      day_sum     = {1'b0, time_ff.day} + {5'd0, hour_carry};
      days_in_month = ccam_pkg::month_len(time_ff.month, leap_ff);
      day_carry   = (day_sum > ccam_pkg::FEB_SHORT_DAYS) && (day_sum > {1'b0, days_in_month});
      month_sum   = {1'b0, time_ff.month} + {4'd0, day_carry};
      month_carry = (month_sum > ccam_pkg::MONTHS_PER_YEAR);

      tick_time.second = sec_carry   ? 6'd0 : sec_sum[5:0];
      tick_time.minute = min_carry   ? 6'd0 : min_sum[5:0];
      tick_time.hour   = hour_carry  ? 5'd0 : hour_sum[4:0];
      tick_time.day    = day_carry   ? ccam_pkg::DAY_DEFAULT : day_sum[4:0];
      tick_time.month  = month_carry ? ccam_pkg::MONTH_DEFAULT : month_sum[3:0];
      tick_year        = month_carry ? (year_ff + YEAR_BITS'(1)) : year_ff;
   end

   always_comb begin
      if (load_en) begin
         time_next = load_time;
         year_next = load_year;
      end else if (tick_en) begin
         time_next = tick_time;
         year_next = tick_year;
      end else begin
         time_next = time_ff;
         year_next = year_ff;
      end
   end

   // The leap flag trails the year register, updating in the cycle after it. After a year
   // carry the month is January, so the stale flag is never consulted; a
   // load takes the flag of the loaded year directly.
   assign leap_year_src = load_en ? load_year : year_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.second <= 6'd0;
         time_ff.minute <= 6'd0;
         time_ff.hour   <= 5'd0;
         time_ff.day    <= ccam_pkg::DAY_DEFAULT;
         time_ff.month  <= ccam_pkg::MONTH_DEFAULT;
         year_ff        <= YEAR_RESET;
         leap_ff        <= ccam_pkg::leap_of(16'(YEAR_RESET));
      end else begin
         time_ff <= time_next;
         year_ff <= year_next;
         leap_ff <= ccam_pkg::leap_of(16'(leap_year_src));
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ccam_alarm.sv =====
// ----------------------------------------------------------------------------
// Calendar clock alarm compare
// Matches the updated time against the alarm registers under the alarm mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccam_alarm #(
   parameter int YEAR_BITS = 16
) (
   input  ccam_pkg::alarm_cfg_type       alarm_cfg,
   input  wire logic [YEAR_BITS-1:0]     alarm_year,
   input  ccam_pkg::time_type            time_now,
   input  wire logic [YEAR_BITS-1:0]     year_now,
   output logic                          match
);

   logic sec_eq;
   logic min_eq;
   logic hour_eq;
   logic day_eq;
   logic month_eq;
   logic year_eq;

   always_comb begin
      sec_eq   = (time_now.second == alarm_cfg.second);
      min_eq   = (time_now.minute == alarm_cfg.minute);
      hour_eq  = (time_now.hour   == alarm_cfg.hour);
      day_eq   = (time_now.day    == alarm_cfg.day);
      month_eq = (time_now.month  == alarm_cfg.month);
      year_eq  = (year_now        == alarm_year);

      // Each higher mode adds one field; mode 7 compares everything.
      match = (alarm_cfg.mode != ccam_pkg::ALARM_OFF) && sec_eq
           && ((alarm_cfg.mode < ccam_pkg::ALARM_MMSS)         || min_eq)
           && ((alarm_cfg.mode < ccam_pkg::ALARM_HHMMSS)       || hour_eq)
           && ((alarm_cfg.mode < ccam_pkg::ALARM_DDHHMMSS)     || day_eq)
           && ((alarm_cfg.mode < ccam_pkg::ALARM_MMDDHHMMSS)   || month_eq)
           && ((alarm_cfg.mode < ccam_pkg::ALARM_YYMMDDHHMMSS) || year_eq);
   end

endmodule

`default_nettype wire

// ===== rtl/calendar_clock_with_alarm_match.sv =====
// ----------------------------------------------------------------------------
// Calendar clock with alarm match
// Real-time calendar advanced by tick words and set by load words, with an
// alarm compare on every enabled tick and one response word per request.
//
//   Channel | Ports                          | Direction | Moves
//   --------+--------------------------------+-----------+------------------
//   req     | req_valid, req_stall, req_*    | in        | tick or load word
//   rsp     | rsp_valid, rsp_stall, rsp_*    | out       | time + alarm word
//   csr     | csr_write, csr_index, csr_wdata| in        | register write
//
// One request word is taken every cycle while req is not stalled; a response
// appears once its request has passed the request register, then the response
// register. The rate is set by the update of the time counters, which closes
// on itself. Reset is synchronous and active high; the time resets to
// 2000-01-01 00:00:00 and the clock is disabled. A stall on rsp holds the
// response register and, once the request register is also full, stalls req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_with_alarm_match #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_type,
   input  wire logic [15:0]                          req_load_year,
   input  wire logic [3:0]                           req_load_month,
   input  wire logic [4:0]                           req_load_day,
   input  wire logic [4:0]                           req_load_hour,
   input  wire logic [5:0]                           req_load_minute,
   input  wire logic [5:0]                           req_load_second,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_alarm_hit,
   output logic      [5:0]                           rsp_cur_second,
   output logic      [5:0]                           rsp_cur_minute,
   output logic      [4:0]                           rsp_cur_hour,
   output logic      [4:0]                           rsp_cur_day,
   output logic      [3:0]                           rsp_cur_month,
   output logic      [15:0]                          rsp_cur_year,

   input  wire logic                                 csr_write,
   input  wire logic [ccam_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ccam_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // Request register.
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   ccam_pkg::req_kind_type  s1_type_ff;
   ccam_pkg::time_type      s1_time_ff;
   logic [YEAR_BITS-1:0]    s1_year_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_hit_ff;
   logic                    rsp_hit_in;
   ccam_pkg::time_type      rsp_time_ff;
   logic [YEAR_BITS-1:0]    rsp_year_ff;

   logic                    req_accept;
   logic                    s1_move;
   logic                    s1_fire;
   logic                    tick_en;
   logic                    load_en;

   ccam_pkg::alarm_cfg_type alarm_cfg;
   logic [YEAR_BITS-1:0]    alarm_year;
   logic                    enable;
   ccam_pkg::time_type      time_next;
   logic [YEAR_BITS-1:0]    year_next;
   logic                    alarm_fire;

   // The request register drains whenever the response register is empty or
   // being taken, so a new word can enter every cycle.
   assign s1_move    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_move;
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   assign load_en = s1_fire && (s1_type_ff == ccam_pkg::REQ_LOAD);
   assign tick_en = s1_fire && (s1_type_ff == ccam_pkg::REQ_TICK) && enable;

   // Loads never raise the alarm; a disabled tick does not either.
   assign rsp_hit_in = tick_en && alarm_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff        <= ccam_pkg::req_kind_type'(req_type);
         s1_time_ff.second <= req_load_second;
         s1_time_ff.minute <= req_load_minute;
         s1_time_ff.hour   <= req_load_hour;
         s1_time_ff.day    <= req_load_day;
         s1_time_ff.month  <= req_load_month;
         s1_year_ff        <= req_load_year[YEAR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_time_ff <= time_next;
         rsp_year_ff <= year_next;
      end
   end

   ccam_csr #(
      .YEAR_BITS (YEAR_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .alarm_cfg  (alarm_cfg),
      .alarm_year (alarm_year),
      .enable     (enable)
   );

   ccam_time #(
      .YEAR_BITS (YEAR_BITS)
   ) u_time (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_en),
      .load_en   (load_en),
      .load_time (s1_time_ff),
      .load_year (s1_year_ff),
      .time_next (time_next),
      .year_next (year_next)
   );

   // The compare sees the time as it stands after this word's update.
   ccam_alarm #(
      .YEAR_BITS (YEAR_BITS)
   ) u_alarm (
      .alarm_cfg  (alarm_cfg),
      .alarm_year (alarm_year),
      .time_now   (time_next),
      .year_now   (year_next),
      .match      (alarm_fire)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alarm_hit  = rsp_hit_ff;
   assign rsp_cur_second = rsp_time_ff.second;
   assign rsp_cur_minute = rsp_time_ff.minute;
   assign rsp_cur_hour   = rsp_time_ff.hour;
   assign rsp_cur_day    = rsp_time_ff.day;
   assign rsp_cur_month  = rsp_time_ff.month;
   assign rsp_cur_year   = 16'(rsp_year_ff);

`ifndef SYNTHESIS
   // A word leaving the request register always lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("request word lost between stages");

   // A held request word keeps its payload while the response side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_time_ff)
                                     && $stable(s1_year_ff) && $stable(s1_type_ff)))
      else $error("stalled request word changed");

   // A load word never reports an alarm.
   assert property (@(posedge clock) disable iff (reset)
      load_en |=> !rsp_hit_ff)
      else $error("alarm raised on a load word");

   // A tick while disabled leaves the time untouched and raises no alarm.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_type_ff == ccam_pkg::REQ_TICK) && !enable)
         |-> ((time_next == u_time.time_ff) && (year_next == u_time.year_ff)
              && !rsp_hit_in))
      else $error("disabled tick moved the time");
`endif

endmodule

`default_nettype wire

// ===== bench/calendar_clock_with_alarm_match_test.sv =====
// ----------------------------------------------------------------------------
// Calendar clock with alarm match - testbench
// Drives tick and load words into the calendar clock and checks every
// response word against a cycle-free calendar predictor kept in the bench.
// Directed tests cover reset, month and year rollover, leap years, loads out
// of range and the alarm modes. Random phases follow, each with its own alarm
// setting and its own pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_clock_with_alarm_match_test;

   // A response word passes the request register, then the response register.
   localparam int RSP_LATENCY     = 2;
   // Cycles without any accepted word before the run is declared hung.
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int MAX_REPORTS     = 10;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_WORDS     = 55;
   // The mode field is three bits wide; its top code compares every field.
   localparam logic [2:0] ALARM_MODE_TOP = 3'd7;

   // Calendar time at the widths of the block's fields.
   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_time_type;

   // What one response word carries.
   typedef struct packed {
      logic         alarm_hit;
      cal_time_type now;
   } cal_report_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_type;
   logic [15:0]                         req_load_year;
   logic [3:0]                          req_load_month;
   logic [4:0]                          req_load_day;
   logic [4:0]                          req_load_hour;
   logic [5:0]                          req_load_minute;
   logic [5:0]                          req_load_second;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_alarm_hit;
   logic [5:0]                          rsp_cur_second;
   logic [5:0]                          rsp_cur_minute;
   logic [4:0]                          rsp_cur_hour;
   logic [4:0]                          rsp_cur_day;
   logic [3:0]                          rsp_cur_month;
   logic [15:0]                         rsp_cur_year;
   logic                                csr_write;
   logic [ccam_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [ccam_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   calendar_clock_with_alarm_match dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_load_year   (req_load_year),
      .req_load_month  (req_load_month),
      .req_load_day    (req_load_day),
      .req_load_hour   (req_load_hour),
      .req_load_minute (req_load_minute),
      .req_load_second (req_load_second),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alarm_hit   (rsp_alarm_hit),
      .rsp_cur_second  (rsp_cur_second),
      .rsp_cur_minute  (rsp_cur_minute),
      .rsp_cur_hour    (rsp_cur_hour),
      .rsp_cur_day     (rsp_cur_day),
      .rsp_cur_month   (rsp_cur_month),
      .rsp_cur_year    (rsp_cur_year),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Predictor state: the calendar as the block should hold it, and a copy of
   // every configuration register as last written.
   cal_time_type predicted_now;
   logic         cfg_enable;
   logic [2:0]   cfg_mode;
   logic [5:0]   cfg_alarm_second;
   logic [5:0]   cfg_alarm_minute;
   logic [4:0]   cfg_alarm_hour;
   logic [4:0]   cfg_alarm_day;
   logic [3:0]   cfg_alarm_month;
   logic [15:0]  cfg_alarm_year;

   // Response words still owed by the block, oldest first.
   cal_report_type expected_reports[$];

   int failures;
   int send_idle_pct;
   int rsp_stall_pct;

   // ------------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------------

   // Gregorian rule: every fourth year, but a century only when it is also a
   // multiple of four hundred.
   function automatic bit is_leap_year(int year);
      if (year % 4 != 0) return 1'b0;
      if (year % 100 != 0) return 1'b1;
      return (year % 400) == 0;
   endfunction

   // Month codes outside 1..12 count as 30-day months.
   function automatic int days_in_month(int month, int year);
      case (month)
         2:                     return is_leap_year(year) ? 29 : 28;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:               return 30;
      endcase
   endfunction

   // One enabled tick. Each stage of the cascade is tested on every tick,
   // not only when a carry reaches it, so loaded values above range are
   // cleared on the first tick after the load. The sums are kept wide since
   // a carry can push a field one past its width for a moment.
   function automatic cal_time_type next_second(cal_time_type t);
      int sec, min, hr, dd, mon, yr;
      cal_time_type n;
      sec = t.second + 1;
      min = t.minute;
      hr  = t.hour;
      dd  = t.day;
      mon = t.month;
      yr  = t.year;
      if (sec >= 60) begin
         min++;
         sec = 0;
      end
      if (min >= 60) begin
         hr++;
         min = 0;
      end
      if (hr >= 24) begin
         dd++;
         hr = 0;
      end
      // A day of zero is never past the month's end, so it stays until a
      // carry moves it.
      if (dd > days_in_month(mon, yr)) begin
         mon++;
         dd = 1;
      end
      if (mon > 12) begin
         yr  = (yr + 1) & 16'hFFFF;
         mon = 1;
      end
      n.second = 6'(sec);
      n.minute = 6'(min);
      n.hour   = 5'(hr);
      n.day    = 5'(dd);
      n.month  = 4'(mon);
      n.year   = 16'(yr);
      return n;
   endfunction

   // Each mode adds one more field to the compare; the top code behaves as
   // the full year-to-second mode.
   function automatic logic alarm_fires(cal_time_type t);
      logic hit;
      if (cfg_mode == ccam_pkg::ALARM_OFF || t.second != cfg_alarm_second) return 1'b0;
      hit = 1'b1;
      if (cfg_mode >= ccam_pkg::ALARM_MMSS)       hit &= (t.minute == cfg_alarm_minute);
      if (cfg_mode >= ccam_pkg::ALARM_HHMMSS)     hit &= (t.hour == cfg_alarm_hour);
      if (cfg_mode >= ccam_pkg::ALARM_DDHHMMSS)   hit &= (t.day == cfg_alarm_day);
      if (cfg_mode >= ccam_pkg::ALARM_MMDDHHMMSS) hit &= (t.month == cfg_alarm_month);
      if (cfg_mode >= ccam_pkg::ALARM_YYMMDDHHMMSS)
         hit &= (t.year == cfg_alarm_year);
      return hit;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic cal_time_type make_time(int yr, int mon, int dd, int hr, int min,
                                              int sec);
      cal_time_type t;
      t.year   = 16'(yr);
      t.month  = 4'(mon);
      t.day    = 5'(dd);
      t.hour   = 5'(hr);
      t.minute = 6'(min);
      t.second = 6'(sec);
      return t;
   endfunction

   // Any bit pattern at all: ignored payload on ticks, or a load far out of
   // range.
   function automatic cal_time_type random_payload();
      cal_time_type t;
      t.year   = 16'($urandom);
      t.month  = 4'($urandom);
      t.day    = 5'($urandom);
      t.hour   = 5'($urandom);
      t.minute = 6'($urandom);
      t.second = 6'($urandom);
      return t;
   endfunction

   // A valid calendar time, biased toward the end of a minute, hour, day,
   // month and year, toward February and December, and toward the century
   // and wrap years where the leap rule and the year counter are exercised.
   function automatic cal_time_type random_calendar_time();
      cal_time_type t;
      int len;
      case ($urandom_range(5))
         0:       t.year = 16'd1900;
         1:       t.year = 16'd2000;
         2:       t.year = 16'd2024;
         3:       t.year = 16'hFFFF;
         default: t.year = 16'($urandom);
      endcase
      case ($urandom_range(3))
         0:       t.month = 4'd2;
         1:       t.month = 4'd12;
         default: t.month = 4'($urandom_range(1, 12));
      endcase
      len      = days_in_month(t.month, t.year);
      t.day    = $urandom_range(1) ? 5'(len) : 5'($urandom_range(1, len));
      t.hour   = $urandom_range(1) ? 5'd23 : 5'($urandom_range(0, 23));
      t.minute = $urandom_range(1) ? 6'd59 : 6'($urandom_range(0, 59));
      t.second = $urandom_range(1) ? 6'($urandom_range(40, 59)) : 6'($urandom_range(0, 59));
      return t;
   endfunction

   // Sets random bits above a register's width now and then; the block must
   // drop them.
   function automatic logic [15:0] with_junk(logic [15:0] value, int width);
      if ($urandom_range(3) == 0) return value | (16'($urandom) << width);
      return value;
   endfunction

   function automatic string format_report(cal_report_type r);
      return $sformatf("hit %0d %0d-%0d-%0d %0d:%0d:%0d", r.alarm_hit, r.now.year,
                       r.now.month, r.now.day, r.now.hour, r.now.minute, r.now.second);
   endfunction

   function automatic void flag_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Chooses the gap and stall pattern of a phase: none, sender gaps, receiver
   // stalls, then a little of both.
   task automatic set_idle_phase(int phase);
      case (phase % 4)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 46;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 46;
         end
         default: begin
            send_idle_pct = 12;
            rsp_stall_pct = 12;
         end
      endcase
   endtask

   // Presents one request word and returns once it has been accepted. The
   // expected response is worked out as the word goes out; registers never
   // change while words are in flight, so the order is the block's order.
   task automatic send_word(input ccam_pkg::req_kind_type kind, input cal_time_type payload);
      cal_report_type want;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_load_year   <= payload.year;
      req_load_month  <= payload.month;
      req_load_day    <= payload.day;
      req_load_hour   <= payload.hour;
      req_load_minute <= payload.minute;
      req_load_second <= payload.second;

      // A load never raises the alarm, and neither does a disabled tick.
      want.alarm_hit = 1'b0;
      if (kind == ccam_pkg::REQ_LOAD) begin
         predicted_now = payload;
      end else if (cfg_enable) begin
         predicted_now  = next_second(predicted_now);
         want.alarm_hit = alarm_fires(predicted_now);
      end
      want.now = predicted_now;
      expected_reports.push_back(want);

      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Writes one register and mirrors it into the predictor. Only called while
   // the block is idle. Indexes past the last register are ignored.
   task automatic write_reg(input logic [ccam_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [ccam_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         ccam_pkg::CSR_ENABLE:       cfg_enable       = value[0];
         ccam_pkg::CSR_ALARM_MODE:   cfg_mode         = value[2:0];
         ccam_pkg::CSR_ALARM_SECOND: cfg_alarm_second = value[5:0];
         ccam_pkg::CSR_ALARM_MINUTE: cfg_alarm_minute = value[5:0];
         ccam_pkg::CSR_ALARM_HOUR:   cfg_alarm_hour   = value[4:0];
         ccam_pkg::CSR_ALARM_DAY:    cfg_alarm_day    = value[4:0];
         ccam_pkg::CSR_ALARM_MONTH:  cfg_alarm_month  = value[3:0];
         ccam_pkg::CSR_ALARM_YEAR:   cfg_alarm_year   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Stops sending and waits until every owed response has come back, then lets
   // the pipeline drain, so the block is idle for register writes.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic load_and_tick(input cal_time_type t);
      send_word(ccam_pkg::REQ_LOAD, t);
      send_word(ccam_pkg::REQ_TICK, random_payload());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight out of reset the clock is disabled, so the first tick must report the
   // default time unchanged. A load of all-zero fields is taken as given.
   task automatic test_reset_state();
      send_word(ccam_pkg::REQ_TICK, random_payload());
      send_word(ccam_pkg::REQ_LOAD, make_time(0, 0, 0, 0, 0, 0));
      send_word(ccam_pkg::REQ_TICK, random_payload());
   endtask

   // End of a year, a leap February, a century that is not a leap year, and
   // the wrap of the year counter itself.
   task automatic test_calendar_rollover();
      wait_idle();
      write_reg(ccam_pkg::CSR_ENABLE, 16'd1);
      write_reg(ccam_pkg::CSR_ALARM_MODE, 16'(ccam_pkg::ALARM_OFF));
      load_and_tick(make_time(2023, 12, 31, 23, 59, 59));
      load_and_tick(make_time(2024, 2, 28, 23, 59, 59));
      load_and_tick(make_time(1900, 2, 28, 23, 59, 59));
      load_and_tick(make_time(16'hFFFF, 12, 31, 23, 59, 59));
   endtask

   // Loads outside the calendar: every field at its all-ones pattern, month
   // and day of zero, and a day past the end of a 30-day month.
   task automatic test_out_of_range_loads();
      load_and_tick(make_time(16'hFFFF, 15, 31, 31, 63, 63));
      load_and_tick(make_time(2021, 0, 0, 0, 59, 59));
      load_and_tick(make_time(2023, 4, 31, 10, 0, 0));
   endtask

   // The tick lands on 2099-06-15 12:34:56 save in seconds-only mode. The top
   // mode code must match on every field, seconds-only mode must ignore the rest,
   // a wrong year must miss in the full mode, and the off mode must never hit.
   task automatic test_alarm_modes();
      cal_time_type before_alarm;
      before_alarm = make_time(2099, 6, 15, 12, 34, 55);
      wait_idle();
      write_reg(ccam_pkg::CSR_ALARM_SECOND, 16'd56);
      write_reg(ccam_pkg::CSR_ALARM_MINUTE, 16'd34);
      write_reg(ccam_pkg::CSR_ALARM_HOUR, 16'd12);
      write_reg(ccam_pkg::CSR_ALARM_DAY, 16'd15);
      write_reg(ccam_pkg::CSR_ALARM_MONTH, 16'd6);
      write_reg(ccam_pkg::CSR_ALARM_YEAR, 16'd2099);
      write_reg(ccam_pkg::CSR_ALARM_MODE, 16'(ALARM_MODE_TOP));
      load_and_tick(before_alarm);

      wait_idle();
      write_reg(ccam_pkg::CSR_ALARM_MODE, 16'(ccam_pkg::ALARM_SS));
      load_and_tick(make_time(2001, 3, 3, 5, 10, 55));

      wait_idle();
      write_reg(ccam_pkg::CSR_ALARM_MODE, 16'(ccam_pkg::ALARM_YYMMDDHHMMSS));
      write_reg(ccam_pkg::CSR_ALARM_YEAR, 16'hFFFF);
      load_and_tick(before_alarm);

      wait_idle();
      write_reg(ccam_pkg::CSR_ALARM_MODE, 16'(ccam_pkg::ALARM_OFF));
      write_reg(ccam_pkg::CSR_ALARM_YEAR, 16'd0);
      load_and_tick(before_alarm);
   endtask

   // Each phase loads a time near some boundary and aims the alarm a few
   // seconds to a few dozen seconds ahead, so that hits fall across carries.
   // Now and then one alarm field is moved off target to force a near miss.
   // The first eight phases walk through every mode code; one phase always runs
   // with the clock disabled, and the others now and then. Ticks dominate; a few
   // loads, some far out of range, break up the stream.
   task automatic test_random_traffic();
      cal_time_type base, target;
      int ahead, pick;
      logic enable_value;
      logic [2:0] mode_value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         set_idle_phase(phase);
         base = ($urandom_range(7) == 0) ? random_payload() : random_calendar_time();
         target = base;
         ahead = $urandom_range(1, 40);
         repeat (ahead) target = next_second(target);
         if ($urandom_range(3) == 0) target.minute = 6'($urandom_range(0, 59));

         enable_value = (phase == 3) ? 1'b0 : ($urandom_range(9) != 0);
         mode_value   = (phase < 8) ? 3'(phase) : 3'($urandom_range(7));
         write_reg(ccam_pkg::CSR_ENABLE, with_junk(16'(enable_value), 1));
         write_reg(ccam_pkg::CSR_ALARM_MODE, with_junk(16'(mode_value), 3));
         write_reg(ccam_pkg::CSR_ALARM_SECOND, with_junk(16'(target.second), 6));
         write_reg(ccam_pkg::CSR_ALARM_MINUTE, with_junk(16'(target.minute), 6));
         write_reg(ccam_pkg::CSR_ALARM_HOUR, with_junk(16'(target.hour), 5));
         write_reg(ccam_pkg::CSR_ALARM_DAY, with_junk(16'(target.day), 5));
         write_reg(ccam_pkg::CSR_ALARM_MONTH, with_junk(16'(target.month), 4));
         write_reg(ccam_pkg::CSR_ALARM_YEAR, target.year);
         // A write to an index past the last register must change nothing.
         if ($urandom_range(2) == 0)
            write_reg(ccam_pkg::CSR_ALARM_YEAR + 4'($urandom_range(1, 8)), 16'($urandom));

         send_word(ccam_pkg::REQ_LOAD, base);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 90)      send_word(ccam_pkg::REQ_TICK, random_payload());
            else if (pick < 95) send_word(ccam_pkg::REQ_LOAD, random_calendar_time());
            else                send_word(ccam_pkg::REQ_LOAD, random_payload());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, receiver stalls, response checking and watchdog
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver decides at each falling edge whether to stall the next
   // rising edge.
   always @(negedge clock) begin
      rsp_stall <= (!reset && ($urandom_range(99) < rsp_stall_pct));
   end

   // Every accepted response word is matched against the oldest expectation.
   always @(posedge clock) begin : check_reports
      cal_report_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.alarm_hit  = rsp_alarm_hit;
         got.now.second = rsp_cur_second;
         got.now.minute = rsp_cur_minute;
         got.now.hour   = rsp_cur_hour;
         got.now.day    = rsp_cur_day;
         got.now.month  = rsp_cur_month;
         got.now.year   = rsp_cur_year;
         if (expected_reports.size() == 0) begin
            flag_failure({"response word with none expected: ", format_report(got)});
         end else begin
            want = expected_reports.pop_front();
            if (got.alarm_hit !== want.alarm_hit || got.now.second !== want.now.second ||
                got.now.minute !== want.now.minute || got.now.hour !== want.now.hour ||
                got.now.day !== want.now.day || got.now.month !== want.now.month ||
                got.now.year !== want.now.year) begin
               flag_failure({"mismatch: expected ", format_report(want), ", got ",
                             format_report(got)});
            end
         end
      end
   end

   // Ends a hung run: a long stretch with no word accepted on either side.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      // Every input has a known value before the first clock edge.
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = ccam_pkg::REQ_TICK;
      req_load_year   = '0;
      req_load_month  = '0;
      req_load_day    = '0;
      req_load_hour   = '0;
      req_load_minute = '0;
      req_load_second = '0;
      rsp_stall       = 1'b0;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      failures        = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;

      // Predictor starts from the block's reset state.
      predicted_now    = make_time(ccam_pkg::YEAR_DEFAULT, ccam_pkg::MONTH_DEFAULT,
                                   ccam_pkg::DAY_DEFAULT, 0, 0, 0);
      cfg_enable       = 1'b0;
      cfg_mode         = ccam_pkg::ALARM_OFF;
      cfg_alarm_second = '0;
      cfg_alarm_minute = '0;
      cfg_alarm_hour   = '0;
      cfg_alarm_day    = 5'd1;
      cfg_alarm_month  = 4'd1;
      cfg_alarm_year   = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_calendar_rollover();
      test_out_of_range_loads();
      test_alarm_modes();
      test_random_traffic();
      wait_idle();

      if (expected_reports.size() != 0)
         flag_failure($sformatf("%0d response words never arrived",
                                expected_reports.size()));
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
